>>> rtl/iirdf_pkg.sv
// package: shared types and constants for the direct-form i iir filter
`timescale 1ns / 1ps
`default_nettype none

package iirdf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 32;
    localparam int OUT_W    = 32;
    localparam int ACC_W    = 64;
    localparam int CFG_W    = 64;
    localparam int IDX_W    = 3;
    localparam int HIST_N   = 4;
    localparam int NUM_N    = 5;
    localparam int ASHIFT   = 6;
    localparam int QSHIFT   = 22;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [CFG_W-1:0]           t_cfg_data;

    typedef enum logic [IDX_W-1:0] {
        CFG_NUM_B0_B1 = 3'd0,
        CFG_NUM_B2_B3 = 3'd1,
        CFG_NUM_B4    = 3'd2,
        CFG_DEN_A1_A2 = 3'd3,
        CFG_DEN_A3_A4 = 3'd4
    } t_cfg_reg;

endpackage

`default_nettype wire

>>> rtl/iir_direct_form_filter_top.sv
// top level: streaming direct-form i iir filter, order up to four, q3.28 output
// path: an accepted input beat goes through the input and result registers
// throughput: one beat per cycle unless i_out_stall holds a valid result; the
// output feedback takes one multiply-accumulate pass between those registers
// reset: clears both pipeline valids, all coefficients and the sample history
`timescale 1ns / 1ps
`default_nettype none

module iir_direct_form_filter_top #(
    parameter int ORDER = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire iirdf_pkg::t_sample i_sample_in,
    input  wire                   i_clear_history,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output iirdf_pkg::t_out       o_sample_out,
    output logic                  o_saturated,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [iirdf_pkg::IDX_W-1:0] i_cfg_index,
    input  wire iirdf_pkg::t_cfg_data i_cfg_data
);
    import iirdf_pkg::*;

    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_in_clear;

    logic    r_out_valid;
    t_out    r_sample_out;
    logic    r_saturated;

    t_coef   r_coef_b [0:NUM_N-1];
    t_coef   r_coef_a [1:HIST_N];
    t_sample r_past_x [0:HIST_N-1];
    t_out    r_past_y [0:HIST_N-1];

    t_sample hist_x [0:HIST_N-1];
    t_out    hist_y [0:HIST_N-1];

    logic                      advance;
    logic signed [55:0]        prod_b [0:NUM_N-1];
    logic signed [63:0]        prod_a [1:HIST_N];
    t_acc                      acc;
    t_acc                      acc_rnd;
    logic signed [ACC_W-QSHIFT-1:0] y_wide;
    t_out                      n_sample_out;
    logic                      n_saturated;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_saturated = r_saturated;
    assign o_cfg_ready = 1'b1;

    // history as seen by the current beat
    always_comb begin
        for (int i = 0; i < HIST_N; i++) begin
            hist_x[i] = r_in_clear ? '0 : r_past_x[i];
            hist_y[i] = r_in_clear ? '0 : r_past_y[i];
        end
    end

    always_comb begin
        prod_b[0] = r_coef_b[0] * r_in_sample;
        for (int i = 1; i <= HIST_N; i++) begin
            prod_b[i] = r_coef_b[i] * hist_x[i-1];
            prod_a[i] = r_coef_a[i] * hist_y[i-1];
        end
    end

    always_comb begin
        acc = ACC_W'(prod_b[0]);
        for (int i = 1; i <= HIST_N; i++) begin
            if (i <= ORDER) begin
                acc = acc + ACC_W'(prod_b[i]) - (prod_a[i] >>> ASHIFT);
            end
        end
        acc_rnd = acc + (t_acc'(1) <<< (QSHIFT - 1));
        y_wide  = acc_rnd[ACC_W-1:QSHIFT];
        if ((&y_wide[ACC_W-QSHIFT-1:OUT_W-1]) || !(|y_wide[ACC_W-QSHIFT-1:OUT_W-1])) begin
            n_sample_out = y_wide[OUT_W-1:0];
            n_saturated  = 1'b0;
        end else begin
            n_sample_out = y_wide[ACC_W-QSHIFT-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                                  : {1'b0, {(OUT_W-1){1'b1}}};
            n_saturated  = 1'b1;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_sample <= i_sample_in;
            r_in_clear  <= i_clear_history;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sample_out <= n_sample_out;
            r_saturated  <= n_saturated;
        end
    end

    // sample history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_N; i++) begin
                r_past_x[i] <= '0;
                r_past_y[i] <= '0;
            end
        end else if (advance) begin
            r_past_x[0] <= r_in_sample;
            r_past_y[0] <= n_sample_out;
            for (int i = 1; i < HIST_N; i++) begin
                r_past_x[i] <= hist_x[i-1];
                r_past_y[i] <= hist_y[i-1];
            end
        end
    end

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_N; i++) begin
                r_coef_b[i] <= '0;
            end
            for (int i = 1; i <= HIST_N; i++) begin
                r_coef_a[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_B0_B1: begin
                    r_coef_b[0] <= i_cfg_data[31:0];
                    r_coef_b[1] <= i_cfg_data[63:32];
                end
                CFG_NUM_B2_B3: begin
                    r_coef_b[2] <= i_cfg_data[31:0];
                    r_coef_b[3] <= i_cfg_data[63:32];
                end
                CFG_NUM_B4: begin
                    r_coef_b[4] <= i_cfg_data[31:0];
                end
                CFG_DEN_A1_A2: begin
                    r_coef_a[1] <= i_cfg_data[31:0];
                    r_coef_a[2] <= i_cfg_data[63:32];
                end
                CFG_DEN_A3_A4: begin
                    r_coef_a[3] <= i_cfg_data[31:0];
                    r_coef_a[4] <= i_cfg_data[63:32];
                end
                default: begin
                end
            endcase
        end
    end

    // checks
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_saturated) |->
            (r_sample_out == {1'b0, {(OUT_W-1){1'b1}}} ||
             r_sample_out == {1'b1, {(OUT_W-1){1'b0}}}))
        else $error("saturated beat not at a range limit");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_clear) |=>
            (r_past_x[1] == '0 && r_past_y[1] == '0 &&
             r_past_x[HIST_N-1] == '0 && r_past_y[HIST_N-1] == '0))
        else $error("history not cleared");

    a_hold_in_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_sample)))
        else $error("held input beat lost");

    a_newest_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_valid && r_past_y[0] == r_sample_out))
        else $error("feedback history differs from output");

endmodule

`default_nettype wire
